// ----- sv/kth_ancestor_binary_lifting_defines.svh -----
// Assertion macros used by the checker file of the kth-ancestor block.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define KAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define KAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kab_pkg.sv -----
// Types and constants of the kth-ancestor jump-table block.
package kab_pkg;

    localparam int ENTRY_W = 11;

    typedef logic signed [ENTRY_W-1:0] t_entry;

    // Entry value for "no node" (root passed, or no such ancestor).
    localparam t_entry NO_NODE = t_entry'(-1);

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_BUILD = 2'd1;
    localparam t_cmd CMD_QUERY = 2'd2;

endpackage

// ----- sv/kth_ancestor_binary_lifting.sv -----
// Kth-ancestor block: binary-lifting jump table in one memory, run by a small sequencer.
//
// The block keeps a jump table of NODES x LEVELS entries in a single memory with one
// write port and one registered read port; entry (node, level) holds the 2^level-th
// ancestor of node, or -1. A write transfer (command 0) stores the parent of one node
// in level 0 as it is transferred, with no stall; parents that are negative or out of
// range are stored as -1. A build transfer (command 1) fills levels 1 to LEVELS-1 for
// nodes 0 to min(node_count, NODES)-1, level by level, so any node numbering works.
// Each entry reads its level-below jump; if that is no valid node the entry is set to
// -1, else a second read fetches the level-below jump of that node, which is written.
// The single memory read port sets the pace of a build. A query transfer (command 2)
// walks the bits of steps from the least significant one up, a step per bit position
// and a table read per set bit, until no set bits are left or the root is passed, and
// then presents the result. A query of an out-of-range node or with steps bits at or
// above LEVELS answers -1 at once. Command code 3 is taken and dropped. The input is
// stalled from the transfer of an item until its work is finished and its result, if
// any, transferred. Table entries hold no defined value until written; level 0 of a
// node must be written before a build or query uses it. The user must write node_count
// through i_cfg_we/i_cfg_data only while idle; the block does not enforce this.
module kth_ancestor_binary_lifting #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // node_count register
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_data,
    // item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_command,
    input  logic [9:0]          i_node_index,
    input  logic signed [10:0]  i_parent_value,
    input  logic [10:0]         i_steps,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [10:0]  o_ancestor
);

    localparam int NW    = $clog2(NODES);        // node index bits
    localparam int NCW   = $clog2(NODES + 1);    // node count bits
    localparam int LVW   = $clog2(LEVELS);       // level index bits
    localparam int DEPTH = NODES * LEVELS;
    localparam int AW    = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QSTEP = 3'd1;   // query: look at next step bit
    localparam logic [2:0] ST_QWAIT = 3'd2;   // query: jump read returns
    localparam logic [2:0] ST_BRDA  = 3'd3;   // build: read level-below jump of node
    localparam logic [2:0] ST_BWTA  = 3'd4;   // build: first read returns
    localparam logic [2:0] ST_BWTB  = 3'd5;   // build: second read returns, write
    localparam logic [2:0] ST_OUT   = 3'd6;   // result waiting for transfer

    logic [2:0]         r_state, n_state;
    logic [LVW-1:0]     r_lvl,   n_lvl;
    logic [NCW-1:0]     r_node,  n_node;
    logic [NCW-1:0]     r_bcount, n_bcount;
    logic [10:0]        r_k,     n_k;
    kab_pkg::t_entry    r_cur,   n_cur;
    logic [10:0]        r_node_count;

    kab_pkg::t_entry    r_mem [DEPTH];
    kab_pkg::t_entry    r_rdata;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    kab_pkg::t_entry    mem_wdata;

    logic               in_xfer;
    logic               do_adv;
    logic               node_ok;
    logic               parent_ok;
    logic               steps_ok;
    logic [NCW-1:0]     clamp_count;

    // Table layout: level-major, entry (node, level) at level * NODES + node.
    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] node,
                                             input logic [LVW-1:0] lvl);
        return AW'(lvl) * AW'(NODES) + AW'(node);
    endfunction

    function automatic logic [NW-1:0] f_idx(input kab_pkg::t_entry e);
        return NW'($unsigned(e));
    endfunction

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_ancestor  = r_cur;
    assign in_xfer     = i_in_valid && !o_in_stall;

    assign node_ok   = (32'(i_node_index) < 32'(NODES));
    assign parent_ok = !i_parent_value[10] && (32'($unsigned(i_parent_value)) < 32'(NODES));
    assign steps_ok  = ((32'(i_steps) >> LEVELS) == 32'd0);
    assign clamp_count = (32'(r_node_count) > 32'(NODES)) ? NCW'(NODES) : NCW'(r_node_count);

    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_node    = r_node;
        n_bcount  = r_bcount;
        n_k       = r_k;
        n_cur     = r_cur;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = kab_pkg::NO_NODE;
        mem_raddr = '0;
        do_adv    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (i_command)
                        kab_pkg::CMD_WRITE: begin
                            mem_we    = node_ok;
                            mem_waddr = f_addr(NW'(i_node_index), '0);
                            mem_wdata = parent_ok ? i_parent_value : kab_pkg::NO_NODE;
                        end
                        kab_pkg::CMD_BUILD: begin
                            n_bcount = clamp_count;
                            n_node   = '0;
                            n_lvl    = LVW'(1);
                            if (clamp_count != '0) begin
                                n_state = ST_BRDA;
                            end
                        end
                        kab_pkg::CMD_QUERY: begin
                            n_k   = i_steps;
                            n_lvl = '0;
                            if (node_ok && steps_ok) begin
                                n_cur   = kab_pkg::t_entry'({1'b0, i_node_index});
                                n_state = ST_QSTEP;
                            end else begin
                                n_cur   = kab_pkg::NO_NODE;
                                n_state = ST_OUT;
                            end
                        end
                        default: ;   // unused code: dropped
                    endcase
                end
            end
            ST_QSTEP: begin
                // done once no set bits remain or the root was passed
                if (r_k == '0 || r_cur == kab_pkg::NO_NODE) begin
                    n_state = ST_OUT;
                end else if (r_k[0]) begin
                    mem_raddr = f_addr(f_idx(r_cur), r_lvl);
                    n_state   = ST_QWAIT;
                end else begin
                    n_k   = r_k >> 1;
                    n_lvl = r_lvl + LVW'(1);
                end
            end
            ST_QWAIT: begin
                n_cur   = r_rdata;
                n_k     = r_k >> 1;
                n_lvl   = r_lvl + LVW'(1);
                n_state = ST_QSTEP;
            end
            ST_BRDA: begin
                mem_raddr = f_addr(r_node[NW-1:0], r_lvl - LVW'(1));
                n_state   = ST_BWTA;
            end
            ST_BWTA: begin
                if (!r_rdata[10] && (32'($unsigned(r_rdata)) < 32'(NODES))) begin
                    mem_raddr = f_addr(f_idx(r_rdata), r_lvl - LVW'(1));
                    n_state   = ST_BWTB;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = f_addr(r_node[NW-1:0], r_lvl);
                    mem_wdata = kab_pkg::NO_NODE;
                    do_adv    = 1'b1;
                end
            end
            ST_BWTB: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_node[NW-1:0], r_lvl);
                mem_wdata = r_rdata;
                do_adv    = 1'b1;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // build walk: nodes inside, levels outside
        if (do_adv) begin
            if (r_node + NCW'(1) == r_bcount) begin
                n_node = '0;
                if (r_lvl == LVW'(LEVELS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_lvl   = r_lvl + LVW'(1);
                    n_state = ST_BRDA;
                end
            end else begin
                n_node  = r_node + NCW'(1);
                n_state = ST_BRDA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= 11'd1024;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl    <= n_lvl;
        r_node   <= n_node;
        r_bcount <= n_bcount;
        r_k      <= n_k;
        r_cur    <= n_cur;
    end

    // jump table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

// ----- sv/kab_checker.sv -----
// Port-level checker for the kth-ancestor block, bound to its top level.
`include "kth_ancestor_binary_lifting_defines.svh"

module kab_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [1:0]          i_command,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic signed [10:0]  o_ancestor
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // a held result keeps its value
    `KAB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_ancestor), "result dropped or changed while stalled")

    // no new item while a result waits
    `KAB_ASSERT_NOW(a_busy_out, o_out_valid, o_in_stall, "input open while result pending")

    // a query keeps the block busy
    `KAB_ASSERT_NEXT(a_query_busy, in_xfer && i_command == kab_pkg::CMD_QUERY, o_in_stall, "query did not occupy the block")

    // a parent write finishes in its own cycle, with no result
    `KAB_ASSERT_NEXT(a_write_quick, in_xfer && i_command == kab_pkg::CMD_WRITE, !o_in_stall && !o_out_valid, "parent write not single cycle")

endmodule

bind kth_ancestor_binary_lifting kab_checker u_kab_checker (.*);
